// File: rtl/fir_filter_circular_top_macros.svh
// Assertion macros for the circular-delay-line FIR filter.
`ifndef FIR_FILTER_CIRCULAR_TOP_MACROS_SVH
`define FIR_FILTER_CIRCULAR_TOP_MACROS_SVH

`ifndef SYNTH

`define FIRC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("firc: invariant violated");

`define FIRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("firc: implication violated");

`define FIRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("firc: next-cycle check violated");

`else

`define FIRC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define FIRC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FIRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/firc_pkg.sv
// Types and constants shared by the FIR filter modules.
`timescale 1ns / 1ps
`default_nettype none

package firc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int ACC_BITS    = 38;
	localparam int COEF_W      = 6;
	localparam int TAPS_W      = 7;
	localparam int ADDR_W_MAX  = 10;

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_LOAD   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		op_t                     op;
		logic [COEF_W-1:0]       coef_index;
		logic signed [SAMPLE_BITS-1:0] value;
		logic                    block_end;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic                    saturated;
		logic                    block_end_out;
	} rsp_t;

	typedef struct packed {
		logic                    s_we;
		logic [ADDR_W_MAX-1:0]   s_waddr;
		logic signed [SAMPLE_BITS-1:0] s_wdata;
		logic                    w_we;
		logic [ADDR_W_MAX-1:0]   w_waddr;
		logic signed [SAMPLE_BITS-1:0] w_wdata;
		logic                    rd_en;
		logic [ADDR_W_MAX-1:0]   s_raddr;
		logic [ADDR_W_MAX-1:0]   w_raddr;
	} mem_req_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic finish;
		logic block_end;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic slot_free;
	} mac_sts_t;

endpackage

`default_nettype wire

// File: rtl/firc_store.sv
// Sample and weight memories with registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module firc_store
	import firc_pkg::*;
#(
	parameter int MAX_TAPS = 64
) (
	input  wire logic                          clk,
	input  wire mem_req_t                      mem,
	output logic signed [SAMPLE_BITS-1:0]      s_rdata,
	output logic signed [SAMPLE_BITS-1:0]      w_rdata
);

	localparam int AW = $clog2(MAX_TAPS);

	logic signed [SAMPLE_BITS-1:0] smem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] wmem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] s_rd_q;
	logic signed [SAMPLE_BITS-1:0] w_rd_q;

	always_ff @(posedge clk) begin
		if (mem.s_we) begin
			smem[mem.s_waddr[AW-1:0]] <= mem.s_wdata;
		end
		if (mem.rd_en) begin
			s_rd_q <= smem[mem.s_raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem.w_we) begin
			wmem[mem.w_waddr[AW-1:0]] <= mem.w_wdata;
		end
		if (mem.rd_en) begin
			w_rd_q <= wmem[mem.w_raddr[AW-1:0]];
		end
	end

	assign s_rdata = s_rd_q;
	assign w_rdata = w_rd_q;

endmodule

`default_nettype wire

// File: rtl/firc_mac.sv
// Multiply-accumulate pipeline, rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none

module firc_mac
	import firc_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mac_ctl_t                      ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] s_rdata,
	input  wire logic signed [SAMPLE_BITS-1:0] w_rdata,
	output mac_sts_t                           sts,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output rsp_t                               rsp
);

	localparam int QW = ACC_BITS + 1 - FRAC_BITS;

	logic                          vld_s1;
	logic                          vld_s2;
	logic signed [PROD_BITS-1:0]   prod_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          rsp_valid_q;
	rsp_t                          rsp_q;
	logic signed [ACC_BITS:0]      rnd;
	logic [QW-1:0]                 quot;
	logic                          over;
	logic                          under;
	rsp_t                          rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= s_rdata * w_rdata;
		end
		if (ctl.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(ACC_BITS-PROD_BITS){prod_s2[PROD_BITS-1]}}, prod_s2};
		end
		if (ctl.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		rnd   = {acc_q[ACC_BITS-1], acc_q} + (ACC_BITS+1)'(1 << (FRAC_BITS - 1));
		quot  = rnd[ACC_BITS:FRAC_BITS];
		over  = !quot[QW-1] && (|quot[QW-2:SAMPLE_BITS-1]);
		under = quot[QW-1] && !(&quot[QW-2:SAMPLE_BITS-1]);
		rsp_d.saturated     = over || under;
		rsp_d.block_end_out = ctl.block_end;
		if (over) begin
			rsp_d.filtered = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (under) begin
			rsp_d.filtered = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			rsp_d.filtered = quot[SAMPLE_BITS-1:0];
		end
	end

	assign sts.busy      = vld_s1 || vld_s2;
	assign sts.slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire

// File: rtl/firc_ctrl.sv
// Sequencer: clear sweep, coefficient loads, tap walk and write position.
`timescale 1ns / 1ps
`default_nettype none

module firc_ctrl
	import firc_pkg::*;
#(
	parameter int MAX_TAPS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [TAPS_W-1:0] taps,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output mem_req_t               mem,
	output mac_ctl_t               mac_ctl,
	input  wire mac_sts_t          mac_sts
);

	localparam int AW = $clog2(MAX_TAPS);
	localparam int TW = AW + 1;
	localparam int CW = (TW > TAPS_W) ? TW : TAPS_W;

	state_t         state_q;
	state_t         state_d;
	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  pos_q;
	logic [AW-1:0]  t_q;
	logic [AW-1:0]  idx_q;
	logic           be_q;
	logic [CW-1:0]  tap_ext;
	logic [TW-1:0]  taps_eff;
	logic [AW-1:0]  taps_m1;
	logic [TW-1:0]  pos_inc;
	logic [AW-1:0]  pos_next;
	logic           accept;
	logic           coef_ok;
	logic           clr_last;
	logic           walk_last;

	always_comb begin
		tap_ext = CW'(taps);
		if (tap_ext == '0) begin
			taps_eff = TW'(1);
		end else if (tap_ext > CW'(MAX_TAPS)) begin
			taps_eff = TW'(MAX_TAPS);
		end else begin
			taps_eff = TW'(tap_ext);
		end
		taps_m1   = AW'(taps_eff - TW'(1));
		pos_inc   = TW'(pos_q) + TW'(1);
		pos_next  = (pos_inc >= taps_eff) ? '0 : AW'(pos_inc);
		accept    = (state_q == ST_IDLE) && req_valid;
		coef_ok   = 32'(req.coef_index) < 32'(MAX_TAPS);
		clr_last  = (clr_q == AW'(MAX_TAPS - 1));
		walk_last = (t_q == taps_m1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && req.op == OP_FILTER) state_d = ST_MAC;
				else if (accept && req.op == OP_CLEAR) state_d = ST_CLEAR;
			end
			ST_MAC: begin
				if (walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_sts.busy && mac_sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready         = 1'b0;
		mem               = '0;
		mem.s_wdata       = req.value;
		mem.w_wdata       = req.value;
		mem.w_waddr       = ADDR_W_MAX'(req.coef_index);
		mem.s_raddr       = ADDR_W_MAX'(idx_q);
		mem.w_raddr       = ADDR_W_MAX'(t_q);
		mac_ctl           = '0;
		mac_ctl.block_end = be_q;
		case (state_q)
			ST_CLEAR: begin
				mem.s_we    = 1'b1;
				mem.s_waddr = ADDR_W_MAX'(clr_q);
				mem.s_wdata = '0;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (accept && req.op == OP_FILTER) begin
					mem.s_we      = 1'b1;
					mem.s_waddr   = ADDR_W_MAX'(pos_q);
					mac_ctl.start = 1'b1;
				end
				if (accept && req.op == OP_LOAD && coef_ok) begin
					mem.w_we = 1'b1;
				end
			end
			ST_MAC: begin
				mem.rd_en     = 1'b1;
				mac_ctl.issue = 1'b1;
			end
			ST_DRAIN: begin
				mac_ctl.finish = !mac_sts.busy && mac_sts.slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept && req.op == OP_CLEAR) begin
				clr_q <= '0;
				pos_q <= '0;
			end
			if (accept && req.op == OP_FILTER) begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.op == OP_FILTER) begin
			t_q   <= '0;
			idx_q <= pos_q;
			be_q  <= req.block_end;
		end else if (state_q == ST_MAC) begin
			t_q   <= t_q + AW'(1);
			idx_q <= (idx_q == '0) ? taps_m1 : idx_q - AW'(1);
		end
	end

endmodule

`default_nettype wire

// File: rtl/fir_filter_circular_top.sv
// Top level of the circular-delay-line FIR filter.
//
//   channel  signals                         role
//   req      req_valid req_ready req         operation in: filter, load, clear
//   rsp      rsp_valid rsp_ready rsp         filtered sample out
//   cfg      cfg_valid cfg_ready cfg_data    taps_in_use write
//
// A filter transaction makes one MAC issue per tap from the sample and weight
// memory read ports; each issue passes the product and accumulator registers,
// then a result load. A coefficient load is written as it is accepted; ops
// with no meaning are dropped. After reset and after each clear, a sweep zeroes
// every delay-line entry while req_ready is low; cfg writes are always taken.
// A full output register stalls only the end of a filter transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_filter_circular_top_macros.svh"

module fir_filter_circular_top
	import firc_pkg::*;
#(
	parameter int MAX_TAPS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [TAPS_W-1:0] cfg_data
);

	logic [TAPS_W-1:0]             taps_q;
	mem_req_t                      mem;
	mac_ctl_t                      mac_ctl;
	mac_sts_t                      mac_sts;
	logic signed [SAMPLE_BITS-1:0] s_rdata;
	logic signed [SAMPLE_BITS-1:0] w_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_W'(1);
		end else if (cfg_valid) begin
			taps_q <= cfg_data;
		end
	end

	firc_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.taps      (taps_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.mem       (mem),
		.mac_ctl   (mac_ctl),
		.mac_sts   (mac_sts)
	);

	firc_store #(
		.MAX_TAPS (MAX_TAPS)
	) u_store (
		.clk     (clk),
		.mem     (mem),
		.s_rdata (s_rdata),
		.w_rdata (w_rdata)
	);

	firc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.s_rdata   (s_rdata),
		.w_rdata   (w_rdata),
		.sts       (mac_sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`FIRC_ASSERT_IMPLIES(a_no_accept_in_walk, clk, arst_n, mac_ctl.issue, !req_ready)
	`FIRC_ASSERT_IMPLIES(a_finish_drained, clk, arst_n, mac_ctl.finish, !mac_sts.busy && mac_sts.slot_free)
	`FIRC_ASSERT_NEXT(a_finish_shows, clk, arst_n, mac_ctl.finish, rsp_valid)
	`FIRC_ASSERT_ALWAYS(a_one_sample_write, clk, arst_n, !(mem.s_we && mem.rd_en))

endmodule

`default_nettype wire
